// File: rtl/htqp_pkg.sv
// shared constants, payload types and control/status structs for the hash table
package htqp_pkg;

  localparam int Slots = 16;
  localparam int SlotW = $clog2(Slots);
  localparam int CntW  = $clog2(Slots + 1);
  localparam int KeyW  = 32;
  localparam int IdxW  = 4;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  localparam logic OUTCOME_OK   = 1'b0;
  localparam logic OUTCOME_FAIL = 1'b1;

  typedef struct packed {
    logic [1:0]             command;
    logic signed [KeyW-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic            outcome;
    logic [IdxW-1:0] slot_index;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic probe_step;
    logic scan_issue;
    logic commit_ok;
    logic commit_fail;
    logic emit;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic probe_empty;
    logic probe_last;
    logic cmp_live;
    logic cmp_hit;
    logic cmp_last;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/htqp_ram.sv
// generic single-write, single-read ram with registered read data
module htqp_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/htqp_ctrl.sv
// sequencing state machine for insert probing and search/delete scanning
module htqp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_cmd_i,
  input  htqp_pkg::stat_t  stat_i,
  output htqp_pkg::ctrl_t  ctrl_o,
  output logic             in_stall_o
);

  htqp_pkg::state_e state_q, state_d;
  logic scan_end;

  assign scan_end = stat_i.cmp_live && (stat_i.cmp_hit || stat_i.cmp_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htqp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htqp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == htqp_pkg::CMD_INSERT) begin
            state_d = htqp_pkg::ST_INSERT;
          end else if (in_cmd_i == htqp_pkg::CMD_SEARCH ||
                       in_cmd_i == htqp_pkg::CMD_DELETE) begin
            state_d = htqp_pkg::ST_SCAN;
          end else begin
            state_d = htqp_pkg::ST_DONE;
          end
        end
      end
      htqp_pkg::ST_INSERT: begin
        if (stat_i.probe_empty || stat_i.probe_last) begin
          state_d = htqp_pkg::ST_DONE;
        end
      end
      htqp_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = htqp_pkg::ST_DONE;
        end
      end
      htqp_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = htqp_pkg::ST_IDLE;
        end
      end
      default: state_d = htqp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      htqp_pkg::ST_IDLE: begin
        in_stall_o         = 1'b0;
        ctrl_o.load        = in_valid_i;
        // unknown command code fails at once
        ctrl_o.commit_fail = in_valid_i &&
                             in_cmd_i != htqp_pkg::CMD_INSERT &&
                             in_cmd_i != htqp_pkg::CMD_SEARCH &&
                             in_cmd_i != htqp_pkg::CMD_DELETE;
      end
      htqp_pkg::ST_INSERT: begin
        ctrl_o.commit_ok   = stat_i.probe_empty;
        ctrl_o.commit_fail = !stat_i.probe_empty && stat_i.probe_last;
        ctrl_o.probe_step  = !stat_i.probe_empty && !stat_i.probe_last;
      end
      htqp_pkg::ST_SCAN: begin
        ctrl_o.commit_ok   = stat_i.cmp_live && stat_i.cmp_hit;
        ctrl_o.commit_fail = stat_i.cmp_live && !stat_i.cmp_hit && stat_i.cmp_last;
        ctrl_o.scan_issue  = !scan_end && !stat_i.scan_done;
      end
      htqp_pkg::ST_DONE: begin
        ctrl_o.emit = stat_i.out_free;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

// File: rtl/htqp_dp.sv
// key store, valid bits, probe/scan address generation and result registers
module htqp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htqp_pkg::in_item_t  in_item_i,
  input  htqp_pkg::ctrl_t     ctrl_i,
  output htqp_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output htqp_pkg::out_item_t out_item_o
);

  logic [htqp_pkg::KeyW-1:0]  key_q;
  logic [1:0]                 op_q;
  logic [htqp_pkg::SlotW-1:0] home_q, sq_q, cmp_slot_q;
  logic [htqp_pkg::CntW-1:0]  cnt_q;
  logic                       cmp_live_q, cmp_last_q, out_valid_q;
  logic [htqp_pkg::Slots-1:0] valid_q;
  htqp_pkg::out_item_t        res_q, out_q;

  logic [htqp_pkg::KeyW-1:0]  in_key, mag;
  logic [htqp_pkg::SlotW-1:0] home_w, probe_slot, scan_addr, commit_slot;
  logic [htqp_pkg::KeyW-1:0]  rd_key;
  logic                       is_insert, is_delete, ram_we;

  assign in_key = in_item_i.key;
  // most negative key wraps to magnitude 2^31 as an unsigned value
  assign mag    = in_key[htqp_pkg::KeyW-1] ? (htqp_pkg::KeyW'(0) - in_key) : in_key;
  assign home_w = htqp_pkg::SlotW'(mag % htqp_pkg::Slots);

  assign is_insert   = (op_q == htqp_pkg::CMD_INSERT);
  assign is_delete   = (op_q == htqp_pkg::CMD_DELETE);
  assign probe_slot  = home_q + sq_q;
  assign scan_addr   = home_q + htqp_pkg::SlotW'(cnt_q);
  assign commit_slot = is_insert ? probe_slot : cmp_slot_q;
  assign ram_we      = ctrl_i.commit_ok && is_insert;

  htqp_ram #(
    .Width (htqp_pkg::KeyW),
    .Depth (htqp_pkg::Slots)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (probe_slot),
    .wdata_i (key_q),
    .raddr_i (scan_addr),
    .rdata_o (rd_key)
  );

  assign stat_o.probe_empty = !valid_q[probe_slot];
  assign stat_o.probe_last  = (cnt_q == htqp_pkg::CntW'(htqp_pkg::Slots - 1));
  assign stat_o.cmp_live    = cmp_live_q;
  assign stat_o.cmp_hit     = valid_q[cmp_slot_q] && (rd_key == key_q);
  assign stat_o.cmp_last    = cmp_last_q;
  assign stat_o.scan_done   = (cnt_q == htqp_pkg::CntW'(htqp_pkg::Slots));
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      cmp_live_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_live_q <= ctrl_i.scan_issue;
      if (ctrl_i.commit_ok && is_insert) begin
        valid_q[probe_slot] <= 1'b1;
      end else if (ctrl_i.commit_ok && is_delete) begin
        valid_q[cmp_slot_q] <= 1'b0;
      end
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q  <= in_key;
      op_q   <= in_item_i.command;
      home_q <= home_w;
      cnt_q  <= '0;
      sq_q   <= '0;
    end else if (ctrl_i.probe_step) begin
      // (i+1)^2 = i^2 + 2i + 1
      cnt_q <= cnt_q + htqp_pkg::CntW'(1);
      sq_q  <= sq_q + htqp_pkg::SlotW'({cnt_q, 1'b1});
    end else if (ctrl_i.scan_issue) begin
      cnt_q <= cnt_q + htqp_pkg::CntW'(1);
    end
    if (ctrl_i.scan_issue) begin
      cmp_slot_q <= scan_addr;
      cmp_last_q <= (cnt_q == htqp_pkg::CntW'(htqp_pkg::Slots - 1));
    end
    if (ctrl_i.commit_ok) begin
      res_q.outcome    <= htqp_pkg::OUTCOME_OK;
      res_q.slot_index <= htqp_pkg::IdxW'(commit_slot);
    end else if (ctrl_i.commit_fail) begin
      res_q.outcome    <= htqp_pkg::OUTCOME_FAIL;
      res_q.slot_index <= '0;
    end
    if (ctrl_i.emit) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_insert_takes_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit_ok && is_insert |-> !valid_q[probe_slot])
    else $error("insert committed to an occupied slot");

  a_insert_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit_ok && is_insert |=> valid_q[$past(probe_slot)])
    else $error("inserted slot not marked valid");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit_ok && !is_insert |-> cmp_live_q && valid_q[cmp_slot_q])
    else $error("search or delete matched an empty slot");

  a_delete_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit_ok && is_delete |=> !valid_q[$past(cmp_slot_q)])
    else $error("deleted slot still valid");

  a_one_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.commit_ok && ctrl_i.commit_fail))
    else $error("success and failure committed together");

endmodule

// File: rtl/hash_table_quadratic_probe.sv
// top level of the open-addressed hash table with quadratic-probe insert
// Open-addressed table of 16 signed 32-bit keys, one valid bit per slot. Each
// item carries a command (insert, search, delete) and a key and yields exactly
// one result item: outcome 0 with the slot index on success, outcome 1 with
// index 0 if all probed slots are taken, the key is absent or command unknown.
// The home slot is |key| mod 16. Insert checks (home + i*i) mod 16 for i from
// 0 to 15 against the valid bits, one probe per cycle, and writes the key into
// the first empty slot without a duplicate check. Search and delete scan
// linearly from home with wrap-around; keys live in a single-port-read ram
// whose read is pipelined one slot ahead of the compare, so one slot is
// checked per cycle. Delete just clears the valid bit. An item is taken in the
// idle state; insert then probes up to 16 slots and search or delete scans up
// to 16 slots (an unknown command skips this step), and the result then moves
// to the output register, waiting while a stalled earlier result still holds
// the output register. Only one item is in flight; a new item is taken while
// the previous result still waits in the output register. Keys need no
// clearing after reset.
module hash_table_quadratic_probe (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item in
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  htqp_pkg::in_item_t  in_item_i,
  // result out
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output htqp_pkg::out_item_t out_item_o
);

  htqp_pkg::ctrl_t ctrl;
  htqp_pkg::stat_t stat;

  // sequencer: idle, insert probing, search/delete scan, result hand-off
  htqp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_item_i.command),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  // key ram, valid bits, slot address math and the output register
  htqp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
